// File: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define OPDC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define OPDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: hdl/opdc_pkg.sv
// Types and constants of the occupancy power-down controller.
// No dependencies; used by every other file but assert_macros.svh.
package opdc_pkg;

    localparam int LIGHT_W         = 4;
    localparam int LIGHT_COUNT_DEF = 4;
    localparam int LEVEL_W         = 8;
    localparam int DELAY_W         = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [DELAY_W-1:0] OFF_DELAY_RST = 16'd5000;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY = 2'd1;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_CHECK = 2'd1,
        KIND_CMD   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MEDIA_OFF     = 2'd0,
        MEDIA_ON      = 2'd1,
        MEDIA_STANDBY = 2'd2
    } t_media;

    typedef struct packed {
        logic               auto_mode;
        logic [DELAY_W-1:0] off_delay;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         mode;
        logic               person;
        logic [LIGHT_W-1:0] cmd_lights;
        logic               cmd_ac_on;
        logic               cmd_ac_heat;
        logic [LEVEL_W-1:0] cmd_ac_level;
        logic [1:0]         cmd_media;
    } t_req;

    typedef struct packed {
        logic [LIGHT_W-1:0] lights;
        logic               ac_on;
        logic               ac_heat;
        logic [LEVEL_W-1:0] ac_level;
        logic [1:0]         media_mode;
        logic               sleep_pending;
        logic               media_off_pending;
        logic               ac_off_pending;
    } t_res;

endpackage

// File: hdl/opdc_req_if.sv
// Request channel of the controller: valid/ready plus command fields.
// Depends on opdc_pkg for field widths.
interface opdc_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   mode;
    logic                         person;
    logic [opdc_pkg::LIGHT_W-1:0] cmd_lights;
    logic                         cmd_ac_on;
    logic                         cmd_ac_heat;
    logic [opdc_pkg::LEVEL_W-1:0] cmd_ac_level;
    logic [1:0]                   cmd_media;

    modport source (output valid, mode, person, cmd_lights, cmd_ac_on, cmd_ac_heat,
                    cmd_ac_level, cmd_media, input ready);
    modport sink (input valid, mode, person, cmd_lights, cmd_ac_on, cmd_ac_heat,
                  cmd_ac_level, cmd_media, output ready);
endinterface

// File: hdl/opdc_res_if.sv
// Result channel of the controller: valid/ready plus device status fields.
// Depends on opdc_pkg for field widths.
interface opdc_res_if;
    logic                         valid;
    logic                         ready;
    logic [opdc_pkg::LIGHT_W-1:0] lights;
    logic                         ac_on;
    logic                         ac_heat;
    logic [opdc_pkg::LEVEL_W-1:0] ac_level;
    logic [1:0]                   media_mode;
    logic                         sleep_pending;
    logic                         media_off_pending;
    logic                         ac_off_pending;

    modport source (output valid, lights, ac_on, ac_heat, ac_level, media_mode,
                    sleep_pending, media_off_pending, ac_off_pending, input ready);
    modport sink (input valid, lights, ac_on, ac_heat, ac_level, media_mode,
                  sleep_pending, media_off_pending, ac_off_pending, output ready);
endinterface

// File: hdl/opdc_cfg_regs.sv
// Configuration registers: auto mode and power-down delay.
// Depends on opdc_pkg.
module opdc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [opdc_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [opdc_pkg::CFG_DATA_W-1:0] i_wdata,
    output opdc_pkg::t_cfg                  o_cfg
);

    logic                         r_auto_mode;
    logic [opdc_pkg::DELAY_W-1:0] r_off_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_mode <= 1'b1;
            r_off_delay <= opdc_pkg::OFF_DELAY_RST;
        end else if (i_we) begin
            unique case (i_idx)
                opdc_pkg::CFG_AUTO_MODE: r_auto_mode <= i_wdata[0];
                opdc_pkg::CFG_OFF_DELAY: r_off_delay <= i_wdata[opdc_pkg::DELAY_W-1:0];
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    assign o_cfg.auto_mode = r_auto_mode;
    assign o_cfg.off_delay = r_off_delay;

endmodule

// File: hdl/opdc_core.sv
// Device state registers and the next-state logic for one request.
// Depends on opdc_pkg; o_res is the state after the current request.
module opdc_core #(
    parameter int LIGHT_COUNT = opdc_pkg::LIGHT_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  opdc_pkg::t_req i_req,
    input  opdc_pkg::t_cfg i_cfg,
    output opdc_pkg::t_res o_res
);

    localparam logic [31:0] MASK_W = (32'd1 << LIGHT_COUNT) - 32'd1;
    localparam logic [opdc_pkg::LIGHT_W-1:0] LIGHT_MASK = MASK_W[opdc_pkg::LIGHT_W-1:0];
    localparam logic [opdc_pkg::DELAY_W-1:0] DELAY_ONE  = opdc_pkg::DELAY_W'(1);

    logic [opdc_pkg::LIGHT_W-1:0] r_lights, n_lights;
    logic                         r_ac_on, n_ac_on;
    logic                         r_ac_heat, n_ac_heat;
    logic [opdc_pkg::LEVEL_W-1:0] r_ac_level, n_ac_level;
    opdc_pkg::t_media             r_media, n_media;
    logic                         r_occupied, n_occupied;
    logic [opdc_pkg::DELAY_W-1:0] r_sleep_cnt, n_sleep_cnt;
    logic [opdc_pkg::DELAY_W-1:0] r_moff_cnt, n_moff_cnt;
    logic [opdc_pkg::DELAY_W-1:0] r_acoff_cnt, n_acoff_cnt;

    logic [opdc_pkg::DELAY_W-1:0] arm_val;
    logic                         sleep_fire, moff_fire, acoff_fire;
    logic                         idle_auto;
    opdc_pkg::t_media             cmd_media;

    assign arm_val    = (i_cfg.off_delay == '0) ? DELAY_ONE : i_cfg.off_delay;
    assign sleep_fire = (r_sleep_cnt == DELAY_ONE);
    assign moff_fire  = (r_moff_cnt  == DELAY_ONE);
    assign acoff_fire = (r_acoff_cnt == DELAY_ONE);
    // room empty under auto mode, with occupancy as it stands (checks don't rearm here)
    assign idle_auto  = i_cfg.auto_mode && !r_occupied;

    always_comb begin
        unique case (i_req.cmd_media)
            opdc_pkg::MEDIA_ON:      cmd_media = opdc_pkg::MEDIA_ON;
            opdc_pkg::MEDIA_STANDBY: cmd_media = opdc_pkg::MEDIA_STANDBY;
            default:                 cmd_media = opdc_pkg::MEDIA_OFF;
        endcase
    end

    always_comb begin
        n_lights    = r_lights;
        n_ac_on     = r_ac_on;
        n_ac_heat   = r_ac_heat;
        n_ac_level  = r_ac_level;
        n_media     = r_media;
        n_occupied  = r_occupied;
        n_sleep_cnt = r_sleep_cnt;
        n_moff_cnt  = r_moff_cnt;
        n_acoff_cnt = r_acoff_cnt;
        unique case (opdc_pkg::t_kind'(i_req.mode))
            opdc_pkg::KIND_TICK: begin
                if (r_sleep_cnt != '0) n_sleep_cnt = r_sleep_cnt - DELAY_ONE;
                if (r_moff_cnt  != '0) n_moff_cnt  = r_moff_cnt - DELAY_ONE;
                if (r_acoff_cnt != '0) n_acoff_cnt = r_acoff_cnt - DELAY_ONE;
                // a sleep firing into standby suppresses a same-tick media-off firing
                if (sleep_fire && r_media == opdc_pkg::MEDIA_ON) begin
                    n_media     = opdc_pkg::MEDIA_STANDBY;
                    n_sleep_cnt = '0;
                    n_moff_cnt  = idle_auto ? arm_val : '0;
                end else if (moff_fire && r_media == opdc_pkg::MEDIA_STANDBY) begin
                    n_media     = opdc_pkg::MEDIA_OFF;
                    n_sleep_cnt = '0;
                    n_moff_cnt  = '0;
                end
                if (acoff_fire && r_ac_on) begin
                    n_ac_on     = 1'b0;
                    n_acoff_cnt = '0;
                end
            end
            opdc_pkg::KIND_CHECK: begin
                n_occupied = i_req.person;
                if (i_cfg.auto_mode) begin
                    if (!i_req.person) begin
                        n_lights = '0;
                        if (r_ac_on && r_acoff_cnt == '0) n_acoff_cnt = arm_val;
                        if (r_media == opdc_pkg::MEDIA_ON && r_sleep_cnt == '0)
                            n_sleep_cnt = arm_val;
                        if (r_media == opdc_pkg::MEDIA_STANDBY && r_moff_cnt == '0)
                            n_moff_cnt = arm_val;
                    end else begin
                        n_sleep_cnt = '0;
                        n_moff_cnt  = '0;
                        n_acoff_cnt = '0;
                    end
                end
            end
            opdc_pkg::KIND_CMD: begin
                n_lights    = i_req.cmd_lights & LIGHT_MASK;
                n_ac_on     = i_req.cmd_ac_on;
                n_ac_heat   = i_req.cmd_ac_heat;
                n_ac_level  = i_req.cmd_ac_level;
                n_acoff_cnt = (idle_auto && i_req.cmd_ac_on) ? arm_val : '0;
                n_media     = cmd_media;
                n_sleep_cnt = (idle_auto && cmd_media == opdc_pkg::MEDIA_ON) ? arm_val : '0;
                n_moff_cnt  = (idle_auto && cmd_media == opdc_pkg::MEDIA_STANDBY)
                              ? arm_val : '0;
            end
            default: ;  // unknown kind: hold state
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lights    <= '0;
            r_ac_on     <= 1'b0;
            r_ac_heat   <= 1'b0;
            r_ac_level  <= '0;
            r_media     <= opdc_pkg::MEDIA_OFF;
            r_occupied  <= 1'b0;
            r_sleep_cnt <= '0;
            r_moff_cnt  <= '0;
            r_acoff_cnt <= '0;
        end else if (i_take) begin
            r_lights    <= n_lights;
            r_ac_on     <= n_ac_on;
            r_ac_heat   <= n_ac_heat;
            r_ac_level  <= n_ac_level;
            r_media     <= n_media;
            r_occupied  <= n_occupied;
            r_sleep_cnt <= n_sleep_cnt;
            r_moff_cnt  <= n_moff_cnt;
            r_acoff_cnt <= n_acoff_cnt;
        end
    end

    assign o_res.lights            = n_lights;
    assign o_res.ac_on             = n_ac_on;
    assign o_res.ac_heat           = n_ac_heat;
    assign o_res.ac_level          = n_ac_level;
    assign o_res.media_mode        = n_media;
    assign o_res.sleep_pending     = (n_sleep_cnt != '0);
    assign o_res.media_off_pending = (n_moff_cnt != '0);
    assign o_res.ac_off_pending    = (n_acoff_cnt != '0);

endmodule

// File: hdl/opdc_out_reg.sv
// Result register with valid/ready handshake.
// Depends on opdc_pkg; loads on every accepted request.
module opdc_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  opdc_pkg::t_res i_res,
    input  logic           i_ready,
    output logic           o_can_load,
    output logic           o_valid,
    output opdc_pkg::t_res o_res
);

    logic           r_valid;
    opdc_pkg::t_res r_res;

    // free when empty or being drained this cycle
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: hdl/occupancy_power_down_controller.sv
// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    mode, person, cmd_lights, cmd_ac_*, cmd_media
// o_res     out  valid/ready    lights, ac_*, media_mode, *_pending
// i_cfg_*   in   write enable   register index, 16-bit data
// One request per cycle unless stalled; its result is registered in the next cycle.
// Throughput is set by the single state update between state and result registers.
// Synchronous active-low reset clears device state and loads default configuration.
// A stalled result blocks a new request only while o_res.ready stays low.
module occupancy_power_down_controller #(
    parameter int LIGHT_COUNT = opdc_pkg::LIGHT_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    opdc_req_if.sink                        i_req,
    opdc_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [opdc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [opdc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    opdc_pkg::t_cfg cfg;
    opdc_pkg::t_req req;
    opdc_pkg::t_res core_res;
    opdc_pkg::t_res out_res;
    logic           can_load;
    logic           take;

    assign req.mode         = i_req.mode;
    assign req.person       = i_req.person;
    assign req.cmd_lights   = i_req.cmd_lights;
    assign req.cmd_ac_on    = i_req.cmd_ac_on;
    assign req.cmd_ac_heat  = i_req.cmd_ac_heat;
    assign req.cmd_ac_level = i_req.cmd_ac_level;
    assign req.cmd_media    = i_req.cmd_media;

    assign i_req.ready = can_load;
    assign take        = i_req.valid && can_load;

    opdc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    opdc_core #(
        .LIGHT_COUNT (LIGHT_COUNT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_req   (req),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    opdc_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_res      (core_res),
        .i_ready    (o_res.ready),
        .o_can_load (can_load),
        .o_valid    (o_res.valid),
        .o_res      (out_res)
    );

    assign o_res.lights            = out_res.lights;
    assign o_res.ac_on             = out_res.ac_on;
    assign o_res.ac_heat           = out_res.ac_heat;
    assign o_res.ac_level          = out_res.ac_level;
    assign o_res.media_mode        = out_res.media_mode;
    assign o_res.sleep_pending     = out_res.sleep_pending;
    assign o_res.media_off_pending = out_res.media_off_pending;
    assign o_res.ac_off_pending    = out_res.ac_off_pending;

endmodule

// File: hdl/opdc_checker.sv
// Port-level checks of the controller, bound to the top level.
// Depends on opdc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module opdc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [1:0] i_media_mode,
    input logic       i_ac_on,
    input logic       i_sleep_pending,
    input logic       i_media_off_pending,
    input logic       i_ac_off_pending
);

    logic res_stall;
    logic ac_timer_shown;
    logic media_busy;
    logic media_ok;

    assign res_stall      = i_res_valid && !i_res_ready;
    assign ac_timer_shown = i_res_valid && i_ac_off_pending;
    assign media_busy     = i_res_valid && (i_sleep_pending || i_media_off_pending);
    // each media countdown runs only in the mode it leaves
    assign media_ok       = (i_sleep_pending && i_media_mode == opdc_pkg::MEDIA_ON) ||
                            (i_media_off_pending && i_media_mode == opdc_pkg::MEDIA_STANDBY);

    `OPDC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_res_valid, "result valid after reset")
    `OPDC_ASSERT(a_hold, i_clk, i_rst_n, res_stall |=> i_res_valid, "result dropped")
    `OPDC_ASSERT(a_ready_empty, i_clk, i_rst_n, !i_res_valid |-> i_req_ready, "blocked while empty")
    `OPDC_ASSERT(a_ac_timer, i_clk, i_rst_n, ac_timer_shown |-> i_ac_on, "AC timer with AC off")
    `OPDC_ASSERT(a_media_timer, i_clk, i_rst_n, media_busy |-> media_ok, "media timer mismatch")

endmodule

bind occupancy_power_down_controller opdc_checker u_opdc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_ready         (i_req.ready),
    .i_res_valid         (o_res.valid),
    .i_res_ready         (o_res.ready),
    .i_media_mode        (o_res.media_mode),
    .i_ac_on             (o_res.ac_on),
    .i_sleep_pending     (o_res.sleep_pending),
    .i_media_off_pending (o_res.media_off_pending),
    .i_ac_off_pending    (o_res.ac_off_pending)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for occupancy_power_down_controller: request/result channels, config port.
// Depends on opdc_pkg, opdc_req_if and opdc_res_if from the RTL.
module tb_top;
    import opdc_pkg::*;

    localparam int          LIGHTS         = LIGHT_COUNT_DEF;
    localparam int          STALL_LIMIT    = 1000;
    localparam int          LONG_HOLD      = 80;
    localparam int          PHASES         = 10;
    localparam int          ITEMS_PER_PHASE = 200;
    localparam int          PLAN_LEN       = 33;

    localparam logic [1:0]           KIND_UNUSED       = 2'd3;
    localparam logic [1:0]           MEDIA_CODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3       = 2'd3;

    typedef enum bit {ROW_REQ, ROW_CFG} t_row;

    typedef struct packed {
        t_row                  row;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_req                  req;
        bit                    typed;
        t_res                  want;
    } t_step;

    localparam t_req NO_REQ = '0;
    localparam t_res NO_RES = '0;

    // Directed sequence; typed rows carry their own expected status.
    localparam t_step PLAN [0:PLAN_LEN-1] = '{
        '{ROW_REQ, '0, '0, '{KIND_TICK, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b1, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_UNUSED, 1'b1, 4'hF, 1'b1, 1'b1, 8'hFF, MEDIA_CODE_UNUSED},
          1'b1, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_CMD, 1'b0, 4'hF, 1'b1, 1'b1, 8'hFF, MEDIA_ON},
          1'b1, '{4'hF, 1'b1, 1'b1, 8'hFF, MEDIA_ON, 1'b1, 1'b0, 1'b1}},
        '{ROW_REQ, '0, '0, '{KIND_CHECK, 1'b1, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b1, '{4'hF, 1'b1, 1'b1, 8'hFF, MEDIA_ON, 1'b0, 1'b0, 1'b0}},
        '{ROW_REQ, '0, '0, '{KIND_CHECK, 1'b0, 4'hF, 1'b1, 1'b1, 8'hFF, MEDIA_ON},
          1'b1, '{4'h0, 1'b1, 1'b1, 8'hFF, MEDIA_ON, 1'b1, 1'b0, 1'b1}},
        '{ROW_REQ, '0, '0, '{KIND_CMD, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_CODE_UNUSED},
          1'b1, NO_RES},
        '{ROW_CFG, CFG_OFF_DELAY, 16'd1, NO_REQ, 1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_CMD, 1'b0, 4'h5, 1'b1, 1'b0, 8'h5A, MEDIA_ON},
          1'b1, '{4'h5, 1'b1, 1'b0, 8'h5A, MEDIA_ON, 1'b1, 1'b0, 1'b1}},
        '{ROW_REQ, '0, '0, '{KIND_TICK, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b1, '{4'h5, 1'b0, 1'b0, 8'h5A, MEDIA_STANDBY, 1'b0, 1'b1, 1'b0}},
        '{ROW_REQ, '0, '0, '{KIND_TICK, 1'b1, 4'hF, 1'b1, 1'b1, 8'hFF, MEDIA_ON},
          1'b1, '{4'h5, 1'b0, 1'b0, 8'h5A, MEDIA_OFF, 1'b0, 1'b0, 1'b0}},
        '{ROW_CFG, CFG_OFF_DELAY, 16'd0, NO_REQ, 1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_CMD, 1'b0, 4'hA, 1'b1, 1'b1, 8'h01, MEDIA_STANDBY},
          1'b1, '{4'hA, 1'b1, 1'b1, 8'h01, MEDIA_STANDBY, 1'b0, 1'b1, 1'b1}},
        '{ROW_REQ, '0, '0, '{KIND_TICK, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b1, '{4'hA, 1'b0, 1'b1, 8'h01, MEDIA_OFF, 1'b0, 1'b0, 1'b0}},
        '{ROW_CFG, CFG_SPARE_2, 16'hFFFF, NO_REQ, 1'b0, NO_RES},
        '{ROW_CFG, CFG_SPARE_3, 16'hFFFF, NO_REQ, 1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_CMD, 1'b0, 4'h3, 1'b1, 1'b0, 8'h33, MEDIA_ON},
          1'b0, NO_RES},
        '{ROW_CFG, CFG_AUTO_MODE, 16'd0, NO_REQ, 1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_CHECK, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_TICK, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_CMD, 1'b0, 4'hF, 1'b1, 1'b0, 8'h10, MEDIA_STANDBY},
          1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_CHECK, 1'b1, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b0, NO_RES},
        '{ROW_CFG, CFG_AUTO_MODE, 16'd1, NO_REQ, 1'b0, NO_RES},
        '{ROW_CFG, CFG_OFF_DELAY, 16'd3, NO_REQ, 1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_CHECK, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_TICK, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_TICK, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_TICK, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_CHECK, 1'b1, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b0, NO_RES},
        '{ROW_CFG, CFG_OFF_DELAY, 16'hFFFF, NO_REQ, 1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_CMD, 1'b0, 4'hF, 1'b1, 1'b1, 8'hFF, MEDIA_ON},
          1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_CHECK, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_TICK, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, MEDIA_OFF},
          1'b0, NO_RES},
        '{ROW_REQ, '0, '0, '{KIND_CMD, 1'b0, 4'hF, 1'b0, 1'b0, 8'h00, MEDIA_STANDBY},
          1'b0, NO_RES}
    };

    localparam logic [0:PHASES-1]   PHASE_AUTO  = 10'b1110111011;
    localparam logic [15:0]         PHASE_DELAY [0:PHASES-1] = '{
        16'd1, 16'd2, 16'd3, 16'd2, 16'd0, 16'd6, 16'hFFFF, 16'd1, 16'd4, 16'd2
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    opdc_req_if req_if ();
    opdc_res_if res_if ();

    occupancy_power_down_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Room model: device state, countdowns and config as the block should hold them.
    logic [LIGHT_W-1:0] st_lights   = '0;
    logic               st_ac_on    = 1'b0;
    logic               st_ac_heat  = 1'b0;
    logic [LEVEL_W-1:0] st_ac_level = '0;
    t_media             st_media    = MEDIA_OFF;
    logic               st_occupied = 1'b0;
    logic [DELAY_W-1:0] cnt_sleep   = '0;
    logic [DELAY_W-1:0] cnt_media_off = '0;
    logic [DELAY_W-1:0] cnt_ac_off  = '0;
    logic               cfg_auto    = 1'b1;
    logic [DELAY_W-1:0] cfg_delay   = OFF_DELAY_RST;

    t_res status_q [$];
    int   mismatches  = 0;
    bit   steady_flow = 1'b0;
    bit   hold_long   = 1'b0;

    function automatic logic [DELAY_W-1:0] arm_ticks();
        return (cfg_delay == '0) ? DELAY_W'(1) : cfg_delay;
    endfunction

    function automatic bit empty_auto();
        return cfg_auto && !st_occupied;
    endfunction

    task automatic apply_media(input t_media m);
        st_media      = m;
        cnt_sleep     = '0;
        cnt_media_off = '0;
        if (empty_auto()) begin
            if (m == MEDIA_ON)
                cnt_sleep = arm_ticks();
            else if (m == MEDIA_STANDBY)
                cnt_media_off = arm_ticks();
        end
    endtask

    task automatic apply_aircon(input logic on, input logic heat, input logic [LEVEL_W-1:0] level);
        st_ac_on    = on;
        st_ac_heat  = heat;
        st_ac_level = level;
        cnt_ac_off  = '0;
        if (empty_auto() && on)
            cnt_ac_off = arm_ticks();
    endtask

    task automatic advance_room(input t_req r, output t_res res);
        bit fire_sleep;
        bit fire_off;
        bit fire_ac;
        fire_sleep = 1'b0;
        fire_off   = 1'b0;
        fire_ac    = 1'b0;
        case (r.mode)
            KIND_TICK: begin
                if (cnt_sleep != '0) begin
                    cnt_sleep  = cnt_sleep - 1'b1;
                    fire_sleep = (cnt_sleep == '0);
                end
                if (cnt_media_off != '0) begin
                    cnt_media_off = cnt_media_off - 1'b1;
                    fire_off      = (cnt_media_off == '0);
                end
                if (cnt_ac_off != '0) begin
                    cnt_ac_off = cnt_ac_off - 1'b1;
                    fire_ac    = (cnt_ac_off == '0);
                end
                // a sleep firing re-arms or stops the media-off count itself
                if (fire_sleep && st_media == MEDIA_ON) begin
                    apply_media(MEDIA_STANDBY);
                    fire_off = 1'b0;
                end
                if (fire_off && st_media == MEDIA_STANDBY)
                    apply_media(MEDIA_OFF);
                if (fire_ac && st_ac_on)
                    apply_aircon(1'b0, st_ac_heat, st_ac_level);
            end
            KIND_CHECK: begin
                st_occupied = r.person;
                if (cfg_auto && !st_occupied) begin
                    st_lights = '0;
                    if (st_ac_on && cnt_ac_off == '0)
                        cnt_ac_off = arm_ticks();
                    if (st_media == MEDIA_ON && cnt_sleep == '0)
                        cnt_sleep = arm_ticks();
                    else if (st_media == MEDIA_STANDBY && cnt_media_off == '0)
                        cnt_media_off = arm_ticks();
                end else if (cfg_auto) begin
                    cnt_sleep     = '0;
                    cnt_media_off = '0;
                    cnt_ac_off    = '0;
                end
            end
            KIND_CMD: begin
                st_lights = r.cmd_lights & LIGHT_W'((1 << LIGHTS) - 1);
                apply_aircon(r.cmd_ac_on, r.cmd_ac_heat, r.cmd_ac_level);
                apply_media((r.cmd_media == MEDIA_CODE_UNUSED) ? MEDIA_OFF
                                                               : t_media'(r.cmd_media));
            end
            default: ;
        endcase
        res.lights            = st_lights;
        res.ac_on             = st_ac_on;
        res.ac_heat           = st_ac_heat;
        res.ac_level          = st_ac_level;
        res.media_mode        = st_media;
        res.sleep_pending     = (cnt_sleep != '0);
        res.media_off_pending = (cnt_media_off != '0);
        res.ac_off_pending    = (cnt_ac_off != '0);
    endtask

    function automatic t_req random_req();
        t_req r;
        int   pick;
        pick           = $urandom_range(0, 99);
        r.mode         = (pick < 45) ? KIND_TICK : (pick < 65) ? KIND_CHECK :
                         (pick < 95) ? KIND_CMD : KIND_UNUSED;
        // lean toward an empty room so the countdowns get to run
        r.person       = ($urandom_range(0, 9) < 3);
        r.cmd_lights   = LIGHT_W'($urandom);
        r.cmd_ac_on    = 1'($urandom);
        r.cmd_ac_heat  = 1'($urandom);
        r.cmd_ac_level = LEVEL_W'($urandom);
        r.cmd_media    = 2'($urandom_range(0, 3));
        return r;
    endfunction

    task automatic offer_request(input t_req r, input bit typed, input t_res want);
        t_res next;
        if (!steady_flow && $urandom_range(0, 7) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.mode         <= r.mode;
        req_if.person       <= r.person;
        req_if.cmd_lights   <= r.cmd_lights;
        req_if.cmd_ac_on    <= r.cmd_ac_on;
        req_if.cmd_ac_heat  <= r.cmd_ac_heat;
        req_if.cmd_ac_level <= r.cmd_ac_level;
        req_if.cmd_media    <= r.cmd_media;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        advance_room(r, next);
        status_q.push_back(typed ? want : next);
    endtask

    // Drop valid and drain every outstanding result before touching config.
    task automatic settle();
        req_if.valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_AUTO_MODE: cfg_auto = data[0];
            CFG_OFF_DELAY: cfg_delay = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_status(input t_res got);
        t_res want;
        if (status_q.size() == 0) begin
            $display("%0t: status %h arrived with no request outstanding", $time, got);
            mismatches++;
        end else begin
            want = status_q.pop_front();
            compare_field("lights", 8'(want.lights), 8'(got.lights));
            compare_field("ac_on", 8'(want.ac_on), 8'(got.ac_on));
            compare_field("ac_heat", 8'(want.ac_heat), 8'(got.ac_heat));
            compare_field("ac_level", want.ac_level, got.ac_level);
            compare_field("media_mode", 8'(want.media_mode), 8'(got.media_mode));
            compare_field("sleep_pending", 8'(want.sleep_pending), 8'(got.sleep_pending));
            compare_field("media_off_pending", 8'(want.media_off_pending),
                          8'(got.media_off_pending));
            compare_field("ac_off_pending", 8'(want.ac_off_pending), 8'(got.ac_off_pending));
        end
    endtask

    initial begin : result_sink
        int unsigned hold_left;
        t_res        got;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got = '{res_if.lights, res_if.ac_on, res_if.ac_heat, res_if.ac_level,
                        res_if.media_mode, res_if.sleep_pending, res_if.media_off_pending,
                        res_if.ac_off_pending};
                check_status(got);
            end
            if (hold_long) begin
                // hold off long enough for the block to back up into the request side
                hold_long = 1'b0;
                hold_left = LONG_HOLD;
                res_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 5);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned stalled_cycles;
        stalled_cycles = 0;
        while (stalled_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_AUTO_MODE;
        i_cfg_wdata         <= '0;
        req_if.valid        <= 1'b0;
        req_if.mode         <= KIND_TICK;
        req_if.person       <= 1'b0;
        req_if.cmd_lights   <= '0;
        req_if.cmd_ac_on    <= 1'b0;
        req_if.cmd_ac_heat  <= 1'b0;
        req_if.cmd_ac_level <= '0;
        req_if.cmd_media    <= MEDIA_OFF;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < PLAN_LEN; k++) begin
            if (PLAN[k].row == ROW_CFG) begin
                settle();
                write_reg(PLAN[k].idx, PLAN[k].data);
            end else begin
                offer_request(PLAN[k].req, PLAN[k].typed, PLAN[k].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(CFG_AUTO_MODE, CFG_DATA_W'(PHASE_AUTO[p]));
            write_reg(CFG_OFF_DELAY, PHASE_DELAY[p]);
            if (p == 4)
                write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom));
            if (p == 1)
                hold_long = 1'b1;
            steady_flow = (p == PHASES - 1);
            repeat (ITEMS_PER_PHASE) offer_request(random_req(), 1'b0, NO_RES);
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && status_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
